/* src/bsc_pkg.sv */
// Package for the Barrett/Shoup constant unit: field widths, pipeline depth,
// transaction structs and per-stage record types. No dependencies.
`default_nettype none
package bsc_pkg;

  localparam int MODULUS_BITS = 60;   // modulus bits actually used, 8..62
  localparam int MOD_W        = 60;
  localparam int OPERAND_W    = 60;
  localparam int K_W          = 6;
  localparam int E_W          = K_W + 1;
  localparam int RATIO_W      = 61;
  localparam int SHOUP_W      = 64;

  // Highest dividend bit that can be set: operand sits at bit 64 and up,
  // the Barrett dividend is 2^(2k) with k at most MODULUS_BITS.
  localparam int TOP_BIT = (2 * MODULUS_BITS > OPERAND_W + 63) ?
                           2 * MODULUS_BITS : OPERAND_W + 63;
  localparam int STEPS   = TOP_BIT + 1;

  typedef struct packed {
    logic [MOD_W-1:0]     modulus;
    logic [OPERAND_W-1:0] operand;
  } in_t;

  typedef struct packed {
    logic [K_W-1:0]     bit_length;
    logic [RATIO_W-1:0] barrett_ratio;
    logic [SHOUP_W-1:0] shoup_factor;
  } out_t;

  typedef struct packed {
    logic [MODULUS_BITS-1:0] m;
    logic [MODULUS_BITS-1:0] mm1;
    logic [OPERAND_W-1:0]    y;
  } pre_t;

  typedef struct packed {
    logic [MODULUS_BITS-1:0] m;
    logic [OPERAND_W-1:0]    y;
    logic [E_W-1:0]          e;
    logic [K_W-1:0]          k;
    logic                    m_zero;
    logic                    y_zero;
    logic [MODULUS_BITS-1:0] rb;
    logic [MODULUS_BITS-1:0] rs;
    logic [RATIO_W-1:0]      qb;
    logic [SHOUP_W-1:0]      qs;
  } stage_t;

endpackage
`default_nettype wire

/* src/barrett_shoup_constant_unit.sv */
// Barrett/Shoup constant unit: bit length, Barrett ratio and Shoup factor
// from one fully pipelined restoring divider pair. Depends on bsc_pkg.
`default_nettype none
// Channel  Dir  Handshake              Payload fields
// in_      in   in_valid / in_stall    in_data: modulus, operand
// out_     out  out_valid / out_stall  out_data: bit_length, barrett_ratio, shoup_factor
//
// One transaction per cycle while no result is parked in the skid register; stages:
// m-1 stage, bit-length stage, one restoring step per dividend bit for both
// divisions side by side, output register. Dividend bit count sets the depth.
// Reset (synchronous, rst_n low) clears the valid bits only.
// A stalled result parks in a one-entry skid register whose full flag is
// in_stall and freezes the pipe, so no transaction is lost or repeated.
module barrett_shoup_constant_unit (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  bsc_pkg::in_t   in_data,
  output logic           out_valid,
  input  wire            out_stall,
  output bsc_pkg::out_t  out_data
);
  import bsc_pkg::*;

  localparam int MB = MODULUS_BITS;

  logic   en;
  logic   pre_v_r;
  pre_t   pre_r;
  pre_t   pre_nxt;
  logic   [STEPS:0] pipe_v_r;
  stage_t pipe_r [0:STEPS];
  stage_t pipe0_nxt;
  out_t   res;
  out_t   out_r;
  out_t   skid_r;
  logic   out_v_r;
  logic   skid_v_r;

  // Whole pipe moves unless the skid register holds a parked result.
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // Stage A: mask the modulus, form m-1 for the bit length search.
  always_comb begin
    logic [63:0] m64;
    m64         = 64'(in_data.modulus);
    pre_nxt.m   = m64[MB-1:0];
    pre_nxt.mm1 = m64[MB-1:0] - MB'(1);
    pre_nxt.y   = in_data.operand;
  end

  // Stage B: k = bit width of m-1 (at least 1), e = 2k.
  always_comb begin
    logic [K_W-1:0] kk;
    kk = K_W'(1);
    for (int i = 0; i < MB; i++) begin
      if (pre_r.mm1[i]) kk = K_W'(i + 1);
    end
    if (pre_r.m == '0) kk = K_W'(1);
    pipe0_nxt.m      = pre_r.m;
    pipe0_nxt.y      = pre_r.y;
    pipe0_nxt.k      = kk;
    pipe0_nxt.e      = {kk, 1'b0};
    pipe0_nxt.m_zero = (pre_r.m == '0);
    pipe0_nxt.y_zero = (pre_r.y == '0);
    pipe0_nxt.rb     = '0;
    pipe0_nxt.rs     = '0;
    pipe0_nxt.qb     = '0;
    pipe0_nxt.qs     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r     <= 1'b0;
      pipe_v_r[0] <= 1'b0;
    end else if (en) begin
      pre_v_r     <= in_valid;
      pipe_v_r[0] <= pre_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r     <= pre_nxt;
      pipe_r[0] <= pipe0_nxt;
    end
  end

  // Divider stages: stage j brings down dividend bit B for both quotients.
  // Only the low quotient bits survive, so they shift in only near the end.
  for (genvar j = 1; j <= STEPS; j++) begin : g_step
    localparam int B = TOP_BIT - j + 1;
    logic   sbit;
    logic   bbit;
    logic   [MB:0] sh_b;
    logic   [MB:0] sh_s;
    logic   [MB:0] df_b;
    logic   [MB:0] df_s;
    stage_t stg_nxt;

    if (B >= 64 && B - 64 < OPERAND_W) begin : g_hi
      assign sbit = pipe_r[j-1].y[B-64];
    end else begin : g_lo
      assign sbit = 1'b0;
    end
    assign bbit = (pipe_r[j-1].e == E_W'(B));

    always_comb begin
      stg_nxt = pipe_r[j-1];
      sh_b    = {pipe_r[j-1].rb, bbit};
      sh_s    = {pipe_r[j-1].rs, sbit};
      df_b    = sh_b - {1'b0, pipe_r[j-1].m};
      df_s    = sh_s - {1'b0, pipe_r[j-1].m};
      if (sh_b >= {1'b0, pipe_r[j-1].m}) begin
        stg_nxt.rb = df_b[MB-1:0];
      end else begin
        stg_nxt.rb = sh_b[MB-1:0];
      end
      if (sh_s >= {1'b0, pipe_r[j-1].m}) begin
        stg_nxt.rs = df_s[MB-1:0];
      end else begin
        stg_nxt.rs = sh_s[MB-1:0];
      end
      if (B < RATIO_W) begin
        stg_nxt.qb = {pipe_r[j-1].qb[RATIO_W-2:0], (sh_b >= {1'b0, pipe_r[j-1].m})};
      end
      if (B < SHOUP_W) begin
        stg_nxt.qs = {pipe_r[j-1].qs[SHOUP_W-2:0], (sh_s >= {1'b0, pipe_r[j-1].m})};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_v_r[j] <= 1'b0;
      end else if (en) begin
        pipe_v_r[j] <= pipe_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) pipe_r[j] <= stg_nxt;
    end
  end

  // Divide-by-zero answers all ones; zero operand forces a zero factor.
  always_comb begin
    res.bit_length    = pipe_r[STEPS].k;
    res.barrett_ratio = pipe_r[STEPS].m_zero ? '1 : pipe_r[STEPS].qb;
    if (pipe_r[STEPS].y_zero) begin
      res.shoup_factor = '0;
    end else if (pipe_r[STEPS].m_zero) begin
      res.shoup_factor = '1;
    end else begin
      res.shoup_factor = pipe_r[STEPS].qs;
    end
  end

  // Output register plus skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (!out_stall) skid_v_r <= 1'b0;
    end else if (pipe_v_r[STEPS]) begin
      if (out_v_r && out_stall) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (!out_stall) out_r <= skid_r;
    end else if (pipe_v_r[STEPS]) begin
      if (out_v_r && out_stall) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // A parked result always has a result ahead of it.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry full while output register empty");

  // Draining the skid moves its transaction to the output.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_stall) |=> (out_v_r && !skid_v_r && out_r == $past(skid_r)))
    else $error("skid entry not moved to output");

  // A result arriving at a stalled output must be parked, not dropped.
  a_park: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_v_r[STEPS] && !skid_v_r && out_v_r && out_stall) |=> skid_v_r)
    else $error("result dropped at stalled output");
`endif

endmodule
`default_nettype wire

/* sim/barrett_shoup_constant_unit_test.sv */
// Self-checking testbench for barrett_shoup_constant_unit: drives modulus/operand
// transactions, predicts bit length, Barrett ratio and Shoup factor, checks results.
// Depends on bsc_pkg and the barrett_shoup_constant_unit RTL.
`timescale 1ns / 100ps

module barrett_shoup_constant_unit_test;
  import bsc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 11;
  // Pipeline depth from the RTL header: one step per dividend bit plus three stages.
  localparam int PIPE_DEPTH   = STEPS + 3;
  localparam int MAX_WAIT     = 8;
  // Slowest correct run is roughly 1600 transactions, each at its longest gap and stall,
  // plus a few full pipeline drains; this leaves a wide margin.
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [MOD_W-1:0] MOD_MAX = '1;
  localparam logic [MOD_W-1:0] MOD_TOP = {1'b1, {(MOD_W-1){1'b0}}};
  // 2^60 - 2^18 + 1, a typical NTT-friendly 60-bit modulus.
  localparam logic [MOD_W-1:0] NTT_MOD = 60'hFFF_FFFF_FFFC_0001;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;

  // Predicted results, oldest first. The block is stateless and in-order, so
  // each accepted transaction appends exactly one entry here.
  out_t        pending_constants[$];
  out_t        oldest;
  int unsigned mismatches;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned cycle_count;
  // While set, neither the sender nor the receiver idles: back-to-back traffic.
  bit          burst_mode;

  barrett_shoup_constant_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: bit length k is the smallest k >= 1 with 2^k >= modulus, the
  // Barrett ratio is 2^(2k)/modulus and the Shoup factor operand*2^64/modulus,
  // both computed as exact 128-bit quotients. A zero modulus answers with all
  // ones, as a hardware divider does; a zero operand always gives a zero factor.
  // Only the low MODULUS_BITS bits of the modulus count.
  // ---------------------------------------------------------------------------
  function automatic out_t predict_constants(input in_t item);
    logic [63:0]          m64;
    logic [MOD_W-1:0]     m;
    logic [OPERAND_W-1:0] y;
    logic [127:0]         divisor;
    logic [127:0]         quotient;
    int unsigned          k;
    out_t                 result;
    m64 = {4'd0, item.modulus} & ((64'd1 << MODULUS_BITS) - 64'd1);
    m = m64[MOD_W-1:0];
    y = item.operand;
    k = 1;
    while (k < 64 && (64'd1 << k) < {4'd0, m}) k++;
    result.bit_length = k[K_W-1:0];
    if (m == '0) begin
      result.barrett_ratio = '1;
      if (y == '0) begin
        result.shoup_factor = '0;
      end else begin
        result.shoup_factor = '1;
      end
    end else begin
      divisor = {68'd0, m};
      quotient = (128'd1 << (2 * k)) / divisor;
      result.barrett_ratio = quotient[RATIO_W-1:0];
      // Operand occupies bits 64 and up of the dividend; keep the low 64 bits
      // of the quotient, which matters only when operand >= modulus.
      quotient = ({68'd0, y} << 64) / divisor;
      result.shoup_factor = quotient[SHOUP_W-1:0];
    end
    return result;
  endfunction

  function automatic logic [59:0] random_bits60();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[59:0];
  endfunction

  // Odd modulus with its top bit at a random position: every bit length from 2 to MOD_W shows up.
  function automatic logic [MOD_W-1:0] random_odd_modulus();
    int unsigned      width;
    logic [MOD_W-1:0] m;
    width = $urandom_range(2, MOD_W);
    m = random_bits60() >> (MOD_W - width);
    m[width-1] = 1'b1;
    m[0] = 1'b1;
    return m;
  endfunction

  function automatic logic [OPERAND_W-1:0] operand_below(input logic [MOD_W-1:0] m);
    logic [63:0] r;
    r = {$urandom, $urandom};
    r = r % {4'd0, m};
    return r[OPERAND_W-1:0];
  endfunction

  function automatic int unsigned draw_wait();
    if (burst_mode) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch in %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Append one prediction at the tail of the expected-result queue.
  task automatic append_prediction(input out_t expected);
    pending_constants = {pending_constants, expected};
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. Called right after the previous transaction was accepted (or
  // with valid low). A zero gap keeps valid high into the next transaction, so
  // valid is never dropped and raised in the same time step. The payload holds
  // while stalled; the prediction is queued at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [MOD_W-1:0] modulus,
                           input logic [OPERAND_W-1:0] operand);
    in_t         item;
    int unsigned gap;
    item.modulus = modulus;
    item.operand = operand;
    gap = draw_wait();
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    append_prediction(predict_constants(item));
    sent_count++;
  endtask

  // Hold the sender off until every outstanding result has been checked.
  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_constants.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // Corner values: zero and unit modulus, smallest and largest moduli, powers
  // of two and their neighbors, operand zero, equal to and above the modulus.
  task automatic test_corner_values();
    send_item('0, '0);
    send_item('0, MOD_MAX);
    send_item(60'd1, '0);
    send_item(60'd1, 60'd1);
    send_item(60'd1, MOD_MAX);
    send_item(60'd2, '0);
    send_item(60'd2, 60'd1);
    send_item(60'd3, 60'd2);
    send_item(60'd4, 60'd3);
    send_item(60'd5, MOD_MAX);
    send_item(60'd7, 60'd7);
    send_item(MOD_MAX, '0);
    send_item(MOD_MAX, 60'd1);
    send_item(MOD_MAX, MOD_MAX - 60'd1);
    send_item(MOD_MAX, MOD_MAX);
    send_item(MOD_TOP, MOD_TOP - 60'd1);
    send_item(MOD_TOP + 60'd1, MOD_TOP);
    send_item(MOD_TOP - 60'd1, MOD_MAX);
    send_item(NTT_MOD, NTT_MOD - 60'd1);
    send_item(NTT_MOD, 60'h555_5555_5555_5555);
    send_item(60'h000_0001_0000_0001, 60'hAAA_AAAA_AAAA_AAAA);
    wait_drained();
  endtask

  // Well-formed traffic: odd moduli of every width from 2 bits up, operand below the modulus.
  task automatic test_odd_moduli(input int unsigned count);
    logic [MOD_W-1:0] m;
    repeat (count) begin
      m = random_odd_modulus();
      send_item(m, operand_below(m));
    end
  endtask

  // Unconstrained fields: even and tiny moduli, zero, operands above modulus.
  task automatic test_raw_fields(input int unsigned count);
    logic [MOD_W-1:0]     m;
    logic [OPERAND_W-1:0] y;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: m = MOD_W'($urandom_range(0, 15));
        1: m = random_bits60() >> $urandom_range(0, MOD_W - 1);
        default: m = random_bits60();
      endcase
      case ($urandom_range(0, 3))
        0: y = OPERAND_W'($urandom_range(0, 3));
        1: y = random_bits60() >> $urandom_range(0, OPERAND_W - 1);
        default: y = random_bits60();
      endcase
      send_item(m, y);
    end
  endtask

  // Full-rate traffic with neither side idling, then back to random gaps.
  task automatic test_back_to_back(input int unsigned count);
    burst_mode = 1'b1;
    test_odd_moduli(count);
    burst_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    burst_mode = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_corner_values();
    test_odd_moduli(1000);
    // Pipeline empties completely here before the next phase starts.
    wait_drained();
    test_raw_fields(380);
    test_back_to_back(150);
    test_odd_moduli(20);

    @(negedge clk) in_valid <= 1'b0;
    while (pending_constants.size() != 0) @(posedge clk);
    // Let any stray result surface before the verdict.
    repeat (PIPE_DEPTH + 16) @(posedge clk);

    $display("Covered corner moduli and operands, odd moduli of every width,");
    $display("raw fields and full-rate bursts: %0d transactions, %0d results checked",
             sent_count, checked_count);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: draws a stall length per result; in burst mode it never stalls.
  // ---------------------------------------------------------------------------
  initial begin : stall_driver
    int unsigned hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = draw_wait();
      repeat (hold) @(negedge clk) out_stall <= 1'b1;
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_constants.size() == 0) begin
        report_mismatch("unexpected transaction", out_data.shoup_factor, '0);
      end else begin
        oldest = pending_constants.pop_front();
        checked_count++;
        if (out_data.bit_length !== oldest.bit_length)
          report_mismatch("bit_length", 64'(out_data.bit_length),
                          64'(oldest.bit_length));
        if (out_data.barrett_ratio !== oldest.barrett_ratio)
          report_mismatch("barrett_ratio", 64'(out_data.barrett_ratio),
                          64'(oldest.barrett_ratio));
        if (out_data.shoup_factor !== oldest.shoup_factor)
          report_mismatch("shoup_factor", out_data.shoup_factor, oldest.shoup_factor);
      end
    end
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_constants.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    mismatches    = 0;
    sent_count    = 0;
    checked_count = 0;
  end

endmodule

/* filelist.f */
src/bsc_pkg.sv
src/barrett_shoup_constant_unit.sv
sim/barrett_shoup_constant_unit_test.sv
